// ----- hw/rtl/sthm_pkg.sv -----
package sthm_pkg;

  // counter width of the wait and step counters
  localparam int CNT_W = 16;
  localparam logic [32:0] CNT_MAX = (33'd1 << CNT_W) - 33'd1;

  typedef logic [CNT_W-1:0] cnt_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FAST_PERIOD = 3'd0,
    REG_SLOW_PERIOD = 3'd1,
    REG_MAX_STEPS   = 3'd2,
    REG_BACKOFF     = 3'd3,
    REG_SETTLE      = 3'd4,
    REG_ENABLE_WAIT = 3'd5
  } reg_idx_t;

  // reset values of the configuration registers
  localparam logic [15:0] FAST_PERIOD_RST = 16'd20;
  localparam logic [15:0] SLOW_PERIOD_RST = 16'd40;
  localparam logic [15:0] MAX_STEPS_RST   = 16'd10000;
  localparam logic [15:0] BACKOFF_RST     = 16'd115;
  localparam logic [7:0]  SETTLE_RST      = 8'd10;
  localparam logic [7:0]  ENABLE_WAIT_RST = 8'd11;

  // result status codes
  localparam logic [1:0] ST_NONE        = 2'd0;
  localparam logic [1:0] ST_HOMED       = 2'd1;
  localparam logic [1:0] ST_MISS_FIRST  = 2'd2;
  localparam logic [1:0] ST_MISS_SECOND = 2'd3;

  // sequencer phases: first pass then second pass
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_ENWAIT     = 4'd1,
    PH_F_SETTLE_T = 4'd2,
    PH_F_APPROACH = 4'd3,
    PH_F_TURN     = 4'd4,
    PH_F_SETTLE_A = 4'd5,
    PH_F_BACKOFF  = 4'd6,
    PH_S_SETTLE_T = 4'd7,
    PH_S_APPROACH = 4'd8,
    PH_S_TURN     = 4'd9,
    PH_S_SETTLE_A = 4'd10,
    PH_S_BACKOFF  = 4'd11
  } phase_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] fast_period_ms;
    logic [15:0] slow_period_ms;
    logic [15:0] max_approach_steps;
    logic [15:0] backoff_steps;
    logic [7:0]  settle_ms;
    logic [7:0]  enable_wait_ms;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    logic       done_res;
    logic       busy_res;
    logic       direction;
    logic       step_pulse;
    logic       driver_enable_n;
  } res_t;

  // clamp a register value to the counter range
  function automatic cnt_t sat_cnt(logic [15:0] v);
    logic [32:0] wide;
    wide = {17'd0, v};
    if (wide > CNT_MAX) begin
      return cnt_t'(CNT_MAX);
    end
    return cnt_t'(wide);
  endfunction

  // a wait of w ticks loads w-1, a zero wait acts as one tick
  function automatic cnt_t wait_load(logic [15:0] w);
    logic [15:0] m;
    m = (w == 16'd0) ? 16'd0 : w - 16'd1;
    return sat_cnt(m);
  endfunction

endpackage

// ----- hw/rtl/sthm_cfg_regs.sv -----
module sthm_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output sthm_pkg::cfg_t      cfg
);

  sthm_pkg::cfg_t cfg_r;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_period_ms     <= sthm_pkg::FAST_PERIOD_RST;
      cfg_r.slow_period_ms     <= sthm_pkg::SLOW_PERIOD_RST;
      cfg_r.max_approach_steps <= sthm_pkg::MAX_STEPS_RST;
      cfg_r.backoff_steps      <= sthm_pkg::BACKOFF_RST;
      cfg_r.settle_ms          <= sthm_pkg::SETTLE_RST;
      cfg_r.enable_wait_ms     <= sthm_pkg::ENABLE_WAIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sthm_pkg::REG_FAST_PERIOD: cfg_r.fast_period_ms     <= cfg_data;
        sthm_pkg::REG_SLOW_PERIOD: cfg_r.slow_period_ms     <= cfg_data;
        sthm_pkg::REG_MAX_STEPS:   cfg_r.max_approach_steps <= cfg_data;
        sthm_pkg::REG_BACKOFF:     cfg_r.backoff_steps      <= cfg_data;
        sthm_pkg::REG_SETTLE:      cfg_r.settle_ms          <= cfg_data[7:0];
        sthm_pkg::REG_ENABLE_WAIT: cfg_r.enable_wait_ms     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/sthm_seq.sv -----
module sthm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                op,
  input  logic                groove_sensor,
  input  sthm_pkg::cfg_t      cfg,
  output sthm_pkg::res_t      res
);

  sthm_pkg::phase_t phase_r, phase_nxt;
  sthm_pkg::cnt_t   wait_count_r, wait_count_nxt;
  sthm_pkg::cnt_t   step_count_r, step_count_nxt;
  logic             dir_r, dir_nxt;
  logic             enable_r, enable_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             pulse, done;

  // phase decode
  logic             second;
  logic             is_appr, is_turn, is_back;
  logic             wait_zero;
  logic [15:0]      period;
  sthm_pkg::cnt_t   sc_eff, limit, settle_load;
  logic             at_limit;

  always_comb begin
    second  = (phase_r >= sthm_pkg::PH_S_SETTLE_T);
    is_appr = (phase_r == sthm_pkg::PH_F_SETTLE_T) || (phase_r == sthm_pkg::PH_F_APPROACH) ||
              (phase_r == sthm_pkg::PH_S_SETTLE_T) || (phase_r == sthm_pkg::PH_S_APPROACH);
    is_turn = (phase_r == sthm_pkg::PH_F_TURN) || (phase_r == sthm_pkg::PH_S_TURN);
    is_back = (phase_r == sthm_pkg::PH_F_SETTLE_A) || (phase_r == sthm_pkg::PH_F_BACKOFF) ||
              (phase_r == sthm_pkg::PH_S_SETTLE_A) || (phase_r == sthm_pkg::PH_S_BACKOFF);
    wait_zero = (wait_count_r == '0);
    period    = second ? cfg.slow_period_ms : cfg.fast_period_ms;
    // a settle phase starts the step count over
    if ((phase_r == sthm_pkg::PH_F_SETTLE_T) || (phase_r == sthm_pkg::PH_F_SETTLE_A) ||
        (phase_r == sthm_pkg::PH_S_SETTLE_T) || (phase_r == sthm_pkg::PH_S_SETTLE_A)) begin
      sc_eff = '0;
    end else begin
      sc_eff = step_count_r;
    end
    limit       = is_appr ? sthm_pkg::sat_cnt(cfg.max_approach_steps)
                          : sthm_pkg::sat_cnt(cfg.backoff_steps);
    at_limit    = (sc_eff >= limit);
    settle_load = sthm_pkg::wait_load({8'd0, cfg.settle_ms});
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (phase_r == sthm_pkg::PH_IDLE) begin
      if (op) begin
        phase_nxt = sthm_pkg::PH_ENWAIT;
      end
    end else if (!wait_zero) begin
      phase_nxt = phase_r;
    end else if (phase_r == sthm_pkg::PH_ENWAIT) begin
      phase_nxt = sthm_pkg::PH_F_SETTLE_T;
    end else if (is_appr) begin
      if (at_limit) begin
        phase_nxt = sthm_pkg::PH_IDLE;
      end else if (groove_sensor) begin
        phase_nxt = second ? sthm_pkg::PH_S_TURN : sthm_pkg::PH_F_TURN;
      end else begin
        phase_nxt = second ? sthm_pkg::PH_S_APPROACH : sthm_pkg::PH_F_APPROACH;
      end
    end else if (is_turn) begin
      phase_nxt = second ? sthm_pkg::PH_S_SETTLE_A : sthm_pkg::PH_F_SETTLE_A;
    end else if (is_back) begin
      if (at_limit) begin
        phase_nxt = second ? sthm_pkg::PH_IDLE : sthm_pkg::PH_S_SETTLE_T;
      end else begin
        phase_nxt = second ? sthm_pkg::PH_S_BACKOFF : sthm_pkg::PH_F_BACKOFF;
      end
    end else begin
      phase_nxt = sthm_pkg::PH_IDLE;
    end
  end

  // counters, driver pins and status
  always_comb begin
    wait_count_nxt = wait_count_r;
    step_count_nxt = step_count_r;
    dir_nxt        = dir_r;
    enable_nxt     = enable_r;
    status_nxt     = status_r;
    pulse          = 1'b0;
    done           = 1'b0;
    if (phase_r == sthm_pkg::PH_IDLE) begin
      if (op) begin
        enable_nxt     = 1'b0;
        status_nxt     = sthm_pkg::ST_NONE;
        wait_count_nxt = sthm_pkg::wait_load({8'd0, cfg.enable_wait_ms});
      end
    end else if (!wait_zero) begin
      wait_count_nxt = sthm_pkg::cnt_t'(wait_count_r - 1'b1);
    end else if (phase_r == sthm_pkg::PH_ENWAIT) begin
      dir_nxt        = 1'b0;
      wait_count_nxt = settle_load;
    end else if (is_appr) begin
      step_count_nxt = sc_eff;
      if (at_limit) begin
        enable_nxt     = 1'b1;
        status_nxt     = second ? sthm_pkg::ST_MISS_SECOND : sthm_pkg::ST_MISS_FIRST;
        wait_count_nxt = '0;
        done           = 1'b1;
      end else begin
        pulse          = 1'b1;
        step_count_nxt = sthm_pkg::cnt_t'(sc_eff + 1'b1);
        wait_count_nxt = groove_sensor ? '0 : sthm_pkg::wait_load(period);
      end
    end else if (is_turn) begin
      dir_nxt        = 1'b1;
      wait_count_nxt = settle_load;
    end else if (is_back) begin
      step_count_nxt = sc_eff;
      if (at_limit) begin
        if (second) begin
          enable_nxt     = 1'b1;
          status_nxt     = sthm_pkg::ST_HOMED;
          wait_count_nxt = '0;
          done           = 1'b1;
        end else begin
          dir_nxt        = 1'b0;
          wait_count_nxt = settle_load;
        end
      end else begin
        pulse          = 1'b1;
        step_count_nxt = sthm_pkg::cnt_t'(sc_eff + 1'b1);
        wait_count_nxt = sthm_pkg::wait_load(period);
      end
    end
  end

  // state update once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sthm_pkg::PH_IDLE;
      wait_count_r <= '0;
      step_count_r <= '0;
      dir_r        <= 1'b0;
      enable_r     <= 1'b1;
      status_r     <= sthm_pkg::ST_NONE;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      wait_count_r <= wait_count_nxt;
      step_count_r <= step_count_nxt;
      dir_r        <= dir_nxt;
      enable_r     <= enable_nxt;
      status_r     <= status_nxt;
    end
  end

  // result fields after this item's update
  always_comb begin
    res.driver_enable_n = enable_nxt;
    res.step_pulse      = pulse;
    res.direction       = dir_nxt;
    res.busy_res        = (phase_nxt != sthm_pkg::PH_IDLE);
    res.done_res        = done;
    res.status          = status_nxt;
  end

endmodule

// ----- hw/rtl/stepper_two_pass_homing.sv -----
// Two-pass stepper homing sequencer, one input item per 1 ms tick.
// Path: input register at the accept edge, then the combinational sequencer update,
// then the result register; a result-side stall holds the item in the input register.
// Throughput: one item per cycle unless the result side stalls, set by the sequencer step.
// Reset: synchronous, active low; driver disabled, idle, counters zero,
// configuration registers back to their reset values.
module stepper_two_pass_homing (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] groove_sensor, [7:1] zero
  input  logic        in_tuser,   // [0] op
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] driver_enable_n, [1] step_pulse, [2] direction,
                                  // [3] busy_res, [4] done_res, [6:5] status, [7] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sthm_pkg::cfg_t cfg;
  sthm_pkg::res_t res;

  logic       s1_valid_r;
  logic       s1_op_r;
  logic       s1_sensor_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_room;
  logic       advance;

  assign cfg_ready = 1'b1;

  sthm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline flow control
  assign out_room  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_room;
  assign in_tready = !s1_valid_r || out_room;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r     <= in_tuser;
      s1_sensor_r <= in_tdata[0];
    end
  end

  sthm_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .op            (s1_op_r),
    .groove_sensor (s1_sensor_r),
    .cfg           (cfg),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_room) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {1'b0, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/stepper_two_pass_homing_test.sv -----
module stepper_two_pass_homing_test;

  // index codes past the last register, writes there must change nothing
  localparam logic [2:0] UNUSED_IDX_LO = 3'd6;
  localparam logic [2:0] UNUSED_IDX_HI = 3'd7;

  localparam int RANDOM_TICKS = 950;
  localparam int RANDOM_PHASES = 6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] groove_sensor, [7:1] zero
  logic        in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;  // [0] driver_enable_n, [1] step_pulse, [2] direction,
                           // [3] busy_res, [4] done_res, [6:5] status, [7] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // homing sequencer mirror
  sthm_pkg::cfg_t   homing_cfg;
  sthm_pkg::phase_t ph;
  sthm_pkg::cnt_t   wait_left;
  sthm_pkg::cnt_t   steps_done;
  logic             dir_q;
  logic             enable_n_q;
  logic [1:0]       status_q;

  sthm_pkg::res_t awaited_results [$];

  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;

  stepper_two_pass_homing dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  // a wait of w ticks reloads w-1, zero acts as one tick
  function automatic sthm_pkg::cnt_t wait_reload(input logic [15:0] w);
    return (w == 16'd0) ? sthm_pkg::cnt_t'(0) : sthm_pkg::cnt_t'(w - 16'd1);
  endfunction

  // chance in percent that the groove shows on a given tick
  function automatic int pick_detect_pct();
    if ($urandom_range(3) == 0) return 0;
    if ($urandom_range(1) != 0) return 100;
    return int'($urandom_range(60, 5));
  endfunction

  // one 1 ms tick through the sequencer, queues the expected result item
  function automatic void predict_homing_tick(input logic start, input logic sensor);
    sthm_pkg::res_t r;
    logic           pulse;
    logic           finishing;
    logic           second;
    logic [1:0]     code;
    logic [15:0]    period;
    pulse = 1'b0;
    finishing = 1'b0;
    code = sthm_pkg::ST_NONE;
    second = (ph >= sthm_pkg::PH_S_SETTLE_T);
    period = second ? homing_cfg.slow_period_ms : homing_cfg.fast_period_ms;
    if (ph == sthm_pkg::PH_IDLE) begin
      // start in idle; direction stays until the enable wait is over
      if (start) begin
        enable_n_q = 1'b0;
        status_q = sthm_pkg::ST_NONE;
        wait_left = wait_reload({8'd0, homing_cfg.enable_wait_ms});
        ph = sthm_pkg::PH_ENWAIT;
      end
    end else if (wait_left != 0) begin
      wait_left = wait_left - sthm_pkg::cnt_t'(1);
    end else if (ph == sthm_pkg::PH_ENWAIT) begin
      dir_q = 1'b0;
      wait_left = wait_reload({8'd0, homing_cfg.settle_ms});
      ph = sthm_pkg::PH_F_SETTLE_T;
    end else begin
      // an expired settle moves on within the same tick
      if (ph == sthm_pkg::PH_F_SETTLE_T || ph == sthm_pkg::PH_S_SETTLE_T) begin
        steps_done = '0;
        ph = sthm_pkg::phase_t'(second ? sthm_pkg::PH_S_APPROACH : sthm_pkg::PH_F_APPROACH);
      end else if (ph == sthm_pkg::PH_F_SETTLE_A || ph == sthm_pkg::PH_S_SETTLE_A) begin
        steps_done = '0;
        ph = sthm_pkg::phase_t'(second ? sthm_pkg::PH_S_BACKOFF : sthm_pkg::PH_F_BACKOFF);
      end
      // counters are as wide as the registers, so no clamping applies
      unique case (ph)
        sthm_pkg::PH_F_APPROACH, sthm_pkg::PH_S_APPROACH: begin
          if (steps_done >= homing_cfg.max_approach_steps) begin
            finishing = 1'b1;
            code = second ? sthm_pkg::ST_MISS_SECOND : sthm_pkg::ST_MISS_FIRST;
          end else begin
            pulse = 1'b1;
            steps_done = steps_done + sthm_pkg::cnt_t'(1);
            if (sensor) begin
              wait_left = '0;
              ph = sthm_pkg::phase_t'(second ? sthm_pkg::PH_S_TURN : sthm_pkg::PH_F_TURN);
            end else begin
              wait_left = wait_reload(period);
            end
          end
        end
        sthm_pkg::PH_F_TURN, sthm_pkg::PH_S_TURN: begin
          dir_q = 1'b1;
          wait_left = wait_reload({8'd0, homing_cfg.settle_ms});
          ph = sthm_pkg::phase_t'(second ? sthm_pkg::PH_S_SETTLE_A : sthm_pkg::PH_F_SETTLE_A);
        end
        sthm_pkg::PH_F_BACKOFF, sthm_pkg::PH_S_BACKOFF: begin
          if (steps_done >= homing_cfg.backoff_steps) begin
            if (second) begin
              finishing = 1'b1;
              code = sthm_pkg::ST_HOMED;
            end else begin
              dir_q = 1'b0;
              wait_left = wait_reload({8'd0, homing_cfg.settle_ms});
              ph = sthm_pkg::PH_S_SETTLE_T;
            end
          end else begin
            pulse = 1'b1;
            steps_done = steps_done + sthm_pkg::cnt_t'(1);
            wait_left = wait_reload(period);
          end
        end
        default: ;
      endcase
    end
    // end of sequence: driver off, outcome latched
    if (finishing) begin
      enable_n_q = 1'b1;
      ph = sthm_pkg::PH_IDLE;
      status_q = code;
      wait_left = '0;
    end
    r.driver_enable_n = enable_n_q;
    r.step_pulse = pulse;
    r.direction = dir_q;
    r.busy_res = (ph != sthm_pkg::PH_IDLE);
    r.done_res = finishing;
    r.status = status_q;
    awaited_results.push_back(r);
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at result %0d, %s: expected %0d, got %0d",
               results_seen, what, want, got);
    end
  endfunction

  // predict on input accept, compare on result accept
  always @(posedge clk) begin : result_check
    sthm_pkg::res_t got;
    sthm_pkg::res_t want;
    if (rst_n && in_tvalid && in_tready) begin
      predict_homing_tick(in_tuser, in_tdata[0]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = sthm_pkg::res_t'(out_tdata[6:0]);
      if (awaited_results.size() == 0) begin
        note_mismatch("result item with none expected", 0, 1);
      end else begin
        want = awaited_results.pop_front();
        if (got.driver_enable_n !== want.driver_enable_n)
          note_mismatch("driver_enable_n", int'(want.driver_enable_n),
                        int'(got.driver_enable_n));
        if (got.step_pulse !== want.step_pulse)
          note_mismatch("step_pulse", int'(want.step_pulse), int'(got.step_pulse));
        if (got.direction !== want.direction)
          note_mismatch("direction", int'(want.direction), int'(got.direction));
        if (got.busy_res !== want.busy_res)
          note_mismatch("busy_res", int'(want.busy_res), int'(got.busy_res));
        if (got.done_res !== want.done_res)
          note_mismatch("done_res", int'(want.done_res), int'(got.done_res));
        if (got.status !== want.status)
          note_mismatch("status", int'(want.status), int'(got.status));
      end
      results_seen++;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!gaps_on) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // send one tick item; entered and left right after a falling edge
  task automatic send_tick(input logic start, input logic sensor);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser <= start;
    in_tdata <= {7'd0, sensor};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    ticks_sent++;
  endtask

  // hold off input until every result is back, then let the pipeline settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    drain_results();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      sthm_pkg::REG_FAST_PERIOD: homing_cfg.fast_period_ms = val;
      sthm_pkg::REG_SLOW_PERIOD: homing_cfg.slow_period_ms = val;
      sthm_pkg::REG_MAX_STEPS:   homing_cfg.max_approach_steps = val;
      sthm_pkg::REG_BACKOFF:     homing_cfg.backoff_steps = val;
      sthm_pkg::REG_SETTLE:      homing_cfg.settle_ms = val[7:0];
      sthm_pkg::REG_ENABLE_WAIT: homing_cfg.enable_wait_ms = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one full homing run from start request back to idle
  task automatic run_homing(input int det_first, input int det_second, input bit noisy);
    int pct;
    send_tick(1'b1, 1'($urandom_range(1)));
    while (ph != sthm_pkg::PH_IDLE) begin
      pct = (ph >= sthm_pkg::PH_S_SETTLE_T) ? det_second : det_first;
      send_tick(noisy ? 1'($urandom_range(1)) : 1'b0, int'($urandom_range(99)) < pct);
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // reset values: groove seen on the first step of each approach,
  // back-off cut short once the fast period has shown on two steps
  task automatic test_reset_config();
    send_tick(1'b1, 1'b0);
    while (!(ph == sthm_pkg::PH_F_BACKOFF && steps_done == sthm_pkg::cnt_t'(2)))
      send_tick(1'b0, 1'b1);
    write_reg(sthm_pkg::REG_BACKOFF, 16'd2);
    while (ph != sthm_pkg::PH_IDLE) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_each_register();
    write_reg(sthm_pkg::REG_FAST_PERIOD, 16'd2);
    write_reg(sthm_pkg::REG_SLOW_PERIOD, 16'd3);
    write_reg(sthm_pkg::REG_MAX_STEPS, 16'd4);
    write_reg(sthm_pkg::REG_BACKOFF, 16'd2);
    write_reg(sthm_pkg::REG_SETTLE, 16'd1);
    write_reg(sthm_pkg::REG_ENABLE_WAIT, 16'd2);
    run_homing(100, 100, 0);
    // miss on first approach, then miss on second
    run_homing(0, 0, 0);
    run_homing(100, 0, 0);
    // start requests while busy are ignored
    run_homing(40, 40, 1);
    // zero step limit misses without stepping
    write_reg(sthm_pkg::REG_MAX_STEPS, 16'd0);
    run_homing(100, 100, 0);
    // zero back-off, zero waits and zero periods
    write_reg(sthm_pkg::REG_MAX_STEPS, 16'd3);
    write_reg(sthm_pkg::REG_BACKOFF, 16'd0);
    write_reg(sthm_pkg::REG_SETTLE, 16'd0);
    write_reg(sthm_pkg::REG_ENABLE_WAIT, 16'd0);
    write_reg(sthm_pkg::REG_FAST_PERIOD, 16'd0);
    write_reg(sthm_pkg::REG_SLOW_PERIOD, 16'd0);
    run_homing(100, 100, 0);
    run_homing(30, 30, 0);
    // writes past the register set
    write_reg(UNUSED_IDX_LO, 16'hFFFF);
    write_reg(UNUSED_IDX_HI, 16'h0001);
    run_homing(100, 100, 0);
  endtask

  task automatic test_extremes();
    write_reg(sthm_pkg::REG_FAST_PERIOD, 16'hFFFF);
    write_reg(sthm_pkg::REG_SLOW_PERIOD, 16'hFFFF);
    write_reg(sthm_pkg::REG_MAX_STEPS, 16'hFFFF);
    write_reg(sthm_pkg::REG_BACKOFF, 16'd0);
    write_reg(sthm_pkg::REG_SETTLE, 16'h00FF);
    write_reg(sthm_pkg::REG_ENABLE_WAIT, 16'hFFFF);
    // longest enable wait and settle, then a short settle for the rest
    send_tick(1'b1, 1'b0);
    while (ph != sthm_pkg::PH_F_TURN) send_tick(1'b0, 1'b1);
    write_reg(sthm_pkg::REG_SETTLE, 16'd1);
    while (ph != sthm_pkg::PH_IDLE) send_tick(1'b0, 1'b1);
    // upper data bits of the 8-bit registers are dropped
    write_reg(sthm_pkg::REG_SETTLE, 16'hFF00);
    write_reg(sthm_pkg::REG_ENABLE_WAIT, 16'hAB00);
    write_reg(sthm_pkg::REG_FAST_PERIOD, 16'd1);
    write_reg(sthm_pkg::REG_SLOW_PERIOD, 16'd1);
    write_reg(sthm_pkg::REG_BACKOFF, 16'd3);
    gaps_on = 1'b0;
    run_homing(100, 100, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int phase_end;
    int k;
    for (k = 0; k < RANDOM_PHASES; k++) begin
      write_reg(sthm_pkg::REG_FAST_PERIOD, 16'($urandom_range(4)));
      write_reg(sthm_pkg::REG_SLOW_PERIOD, 16'($urandom_range(5)));
      write_reg(sthm_pkg::REG_MAX_STEPS, 16'($urandom_range(10)));
      write_reg(sthm_pkg::REG_BACKOFF, 16'($urandom_range(6)));
      write_reg(sthm_pkg::REG_SETTLE, {8'($urandom), 8'($urandom_range(4))});
      write_reg(sthm_pkg::REG_ENABLE_WAIT, {8'($urandom), 8'($urandom_range(4))});
      phase_end = ticks_sent + RANDOM_TICKS / RANDOM_PHASES;
      while (ticks_sent < phase_end) begin
        gaps_on = ($urandom_range(4) != 0);
        if ($urandom_range(9) != 0) begin
          run_homing(pick_detect_pct(), pick_detect_pct(), $urandom_range(3) == 0);
        end else begin
          repeat ($urandom_range(6, 1)) send_tick(1'b0, 1'($urandom_range(1)));
        end
      end
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = sthm_pkg::REG_FAST_PERIOD;
    cfg_data = 16'd0;
    homing_cfg.fast_period_ms = sthm_pkg::FAST_PERIOD_RST;
    homing_cfg.slow_period_ms = sthm_pkg::SLOW_PERIOD_RST;
    homing_cfg.max_approach_steps = sthm_pkg::MAX_STEPS_RST;
    homing_cfg.backoff_steps = sthm_pkg::BACKOFF_RST;
    homing_cfg.settle_ms = sthm_pkg::SETTLE_RST;
    homing_cfg.enable_wait_ms = sthm_pkg::ENABLE_WAIT_RST;
    ph = sthm_pkg::PH_IDLE;
    wait_left = '0;
    steps_done = '0;
    dir_q = 1'b0;
    enable_n_q = 1'b1;
    status_q = sthm_pkg::ST_NONE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_reset_config();
    test_each_register();
    test_extremes();
    test_random();

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule
